FILE: src/pbit_pkg.sv
// shared types and constants for the path versus box hit test
// no dependencies; imported by every module of the block
package pbit_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
    localparam int EXT_WIDTH   = COORD_WIDTH + 1;      // box edges, segment deltas
    localparam int REL_WIDTH   = COORD_WIDTH + 2;      // corner relative to segment start
    localparam int PROD_WIDTH  = REL_WIDTH + EXT_WIDTH;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
    localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

    // requests that can be in flight: queue, two back stages, output register
    localparam int PIPE_CAPACITY = QUEUE_DEPTH + 3;
    localparam int PEND_WIDTH    = $clog2(PIPE_CAPACITY + 1);

    localparam int NUM_CORNERS = 4;

    // configuration register indexes
    localparam logic [1:0] REG_BOX_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOX_TOP    = 2'd1;
    localparam logic [1:0] REG_BOX_WIDTH  = 2'd2;
    localparam logic [1:0] REG_BOX_HEIGHT = 2'd3;

    // closed box with left, top, right and bottom edges, sign-extended
    typedef struct packed {
        logic [EXT_WIDTH-1:0] left;
        logic [EXT_WIDTH-1:0] top;
        logic [EXT_WIDTH-1:0] right;
        logic [EXT_WIDTH-1:0] bottom;
    } box_t;

    // classification of one segment
    typedef struct packed {
        logic live;   // segment exists and its bounding box touches the box
        logic axis;   // vertical, horizontal or zero length
        logic last;   // vertex closes the path
    } seg_flags_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] x1;
        logic [COORD_WIDTH-1:0] y1;
        logic [EXT_WIDTH-1:0]   dx;
        logic [EXT_WIDTH-1:0]   dy;
        seg_flags_t             flags;
    } seg_t;

endpackage

FILE: src/path_box_intersect_test.sv
// top level of the polyline versus box hit test
// depends on pbit_pkg, pbit_front, pbit_fifo and pbit_back
//
// Vertices of a polyline arrive one request per clock on the s_ channel while
// s_ready is high; each segment between consecutive vertices of a path is
// tested against the closed box set through the cfg_ port (touching counts as
// a hit), hits are ORed over the path, and one m_ request carries the answer
// for the vertex flagged with s_path_end. A path of a single vertex answers 0.
// Coordinates are signed Q12.4, box width and height unsigned Q11.4. Sustained
// rate is one vertex per clock while answers are taken; answers pass the queue,
// corner difference and product stages and output register, and the four-corner
// pair of 18x17-bit products is the stage that sets the clock. A four-entry
// queue separates the vertex pairing front from the arithmetic back, and the
// output register lets new vertices flow while an answer waits. cfg_ready is
// always high; the box must be written by the user only while idle (unchecked).
module path_box_intersect_test (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [pbit_pkg::COORD_WIDTH-1:0] cfg_data,
    // vertex requests
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [pbit_pkg::COORD_WIDTH-1:0] s_point_x,
    input  logic [pbit_pkg::COORD_WIDTH-1:0] s_point_y,
    input  logic                             s_path_end,
    // result requests
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_intersects
);
    import pbit_pkg::*;

    logic [COORD_WIDTH-1:0] box_left_reg, box_top_reg;
    logic [SIZE_WIDTH-1:0]  box_width_reg, box_height_reg;
    box_t                   box;

    logic push, full, pop, head_valid;
    seg_t push_data, head;

    // config port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_left_reg   <= '0;
            box_top_reg    <= '0;
            box_width_reg  <= '0;
            box_height_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BOX_LEFT:   box_left_reg   <= cfg_data;
                REG_BOX_TOP:    box_top_reg    <= cfg_data;
                REG_BOX_WIDTH:  box_width_reg  <= cfg_data[SIZE_WIDTH-1:0];
                REG_BOX_HEIGHT: box_height_reg <= cfg_data[SIZE_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // box edges, all four are one bit wider than the coordinates
    always_comb begin
        box.left   = {box_left_reg[COORD_WIDTH-1], box_left_reg};
        box.top    = {box_top_reg[COORD_WIDTH-1], box_top_reg};
        box.right  = box.left + {2'b00, box_width_reg};
        box.bottom = box.top + {2'b00, box_height_reg};
    end

    // front: pairs vertices and classifies segments
    pbit_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .box        (box),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_point_x  (s_point_x),
        .s_point_y  (s_point_y),
        .s_path_end (s_path_end),
        .push       (push),
        .push_data  (push_data),
        .full       (full)
    );

    // segment queue
    pbit_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // back: cross products, side test, accumulation, result register
    pbit_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .box          (box),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_intersects (m_intersects)
    );

endmodule

FILE: src/pbit_fifo.sv
// short segment queue between the front and back parts
// depends on pbit_pkg
module pbit_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pbit_pkg::seg_t push_data,
    output logic           full,
    input  logic           pop,
    output pbit_pkg::seg_t head,
    output logic           head_valid
);
    import pbit_pkg::*;

    seg_t                 entry_reg [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_WIDTH-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == CNT_WIDTH'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/pbit_front.sv
// front part: pairs each vertex with the previous one and classifies the segment
// depends on pbit_pkg
module pbit_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pbit_pkg::box_t               box,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pbit_pkg::COORD_WIDTH-1:0] s_point_x,
    input  logic [pbit_pkg::COORD_WIDTH-1:0] s_point_y,
    input  logic                         s_path_end,
    output logic                         push,
    output pbit_pkg::seg_t               push_data,
    input  logic                         full
);
    import pbit_pkg::*;

    logic [COORD_WIDTH-1:0] prev_x_reg, prev_y_reg;
    logic                   have_prev_reg;
    logic signed [EXT_WIDTH-1:0] x1, y1, x2, y2;
    logic signed [EXT_WIDTH-1:0] min_x, max_x, min_y, max_y;
    logic                   bbox_miss;

    assign s_ready = !full;
    assign push    = s_valid && !full;

    always_comb begin
        x1 = $signed({prev_x_reg[COORD_WIDTH-1], prev_x_reg});
        y1 = $signed({prev_y_reg[COORD_WIDTH-1], prev_y_reg});
        x2 = $signed({s_point_x[COORD_WIDTH-1], s_point_x});
        y2 = $signed({s_point_y[COORD_WIDTH-1], s_point_y});
        min_x = (x1 < x2) ? x1 : x2;
        max_x = (x1 < x2) ? x2 : x1;
        min_y = (y1 < y2) ? y1 : y2;
        max_y = (y1 < y2) ? y2 : y1;
        bbox_miss = (max_x < $signed(box.left))  || (min_x > $signed(box.right)) ||
                    (max_y < $signed(box.top))   || (min_y > $signed(box.bottom));

        push_data.x1         = prev_x_reg;
        push_data.y1         = prev_y_reg;
        push_data.dx         = x2 - x1;
        push_data.dy         = y2 - y1;
        push_data.flags.live = have_prev_reg && !bbox_miss;
        push_data.flags.axis = (x1 == x2) || (y1 == y2);
        push_data.flags.last = s_path_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
        end else if (push) begin
            have_prev_reg <= !s_path_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end else if (push) begin
            prev_x_reg <= s_point_x;
            prev_y_reg <= s_point_y;
        end
    end

endmodule

FILE: src/pbit_back.sv
// back part: corner cross products, side test, path accumulation and result register
// depends on pbit_pkg
module pbit_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  pbit_pkg::box_t box,
    input  pbit_pkg::seg_t head,
    input  logic           head_valid,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_intersects
);
    import pbit_pkg::*;

    // stage a: corners relative to the segment start
    logic                        a_valid_reg;
    logic signed [REL_WIDTH-1:0] ex_reg [NUM_CORNERS];
    logic signed [REL_WIDTH-1:0] ey_reg [NUM_CORNERS];
    logic signed [REL_WIDTH-1:0] ex_next [NUM_CORNERS];
    logic signed [REL_WIDTH-1:0] ey_next [NUM_CORNERS];
    logic signed [EXT_WIDTH-1:0] dx_reg, dy_reg;
    seg_flags_t                  a_flags_reg;

    // stage b: the two products of each corner
    logic                         b_valid_reg;
    logic signed [PROD_WIDTH-1:0] p_reg [NUM_CORNERS];
    logic signed [PROD_WIDTH-1:0] q_reg [NUM_CORNERS];
    seg_flags_t                   b_flags_reg;

    logic [NUM_CORNERS-1:0] above, below;
    logic                   seg_hit;
    logic                   acc_reg;
    logic                   m_valid_reg, m_intersects_reg;
    logic                   a_ld, b_ld, c_adv;

    assign c_adv = b_valid_reg && (!b_flags_reg.last || !m_valid_reg || m_ready);
    assign b_ld  = !b_valid_reg || c_adv;
    assign a_ld  = !a_valid_reg || b_ld;
    assign pop   = head_valid && a_ld;

    assign m_valid      = m_valid_reg;
    assign m_intersects = m_intersects_reg;

    always_comb begin
        logic signed [REL_WIDTH-1:0] x1, y1, cx, cy;
        x1 = REL_WIDTH'($signed(head.x1));
        y1 = REL_WIDTH'($signed(head.y1));
        for (int i = 0; i < NUM_CORNERS; i++) begin
            cx = (i == 1 || i == 2) ? REL_WIDTH'($signed(box.right))
                                    : REL_WIDTH'($signed(box.left));
            cy = (i >= 2) ? REL_WIDTH'($signed(box.bottom))
                          : REL_WIDTH'($signed(box.top));
            ex_next[i] = cx - x1;
            ey_next[i] = cy - y1;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_CORNERS; i++) begin
            above[i] = p_reg[i] > q_reg[i];
            below[i] = p_reg[i] < q_reg[i];
        end
        seg_hit = b_flags_reg.live &&
                  (b_flags_reg.axis || !((&above) || (&below)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            acc_reg     <= 1'b0;
        end else begin
            if (a_ld) begin
                a_valid_reg <= pop;
            end
            if (b_ld) begin
                b_valid_reg <= a_valid_reg;
            end
            // a new answer replaces the one taken in the same cycle
            if (c_adv && b_flags_reg.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (c_adv) begin
                if (b_flags_reg.last) begin
                    acc_reg <= 1'b0;
                end else begin
                    acc_reg <= acc_reg || seg_hit;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                ex_reg[i] <= ex_next[i];
                ey_reg[i] <= ey_next[i];
            end
            dx_reg      <= $signed(head.dx);
            dy_reg      <= $signed(head.dy);
            a_flags_reg <= head.flags;
        end
        if (b_ld && a_valid_reg) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                p_reg[i] <= ex_reg[i] * dy_reg;
                q_reg[i] <= ey_reg[i] * dx_reg;
            end
            b_flags_reg <= a_flags_reg;
        end
        if (c_adv && b_flags_reg.last) begin
            m_intersects_reg <= acc_reg || seg_hit;
        end
    end

endmodule

FILE: src/pbit_checker.sv
// port-level checks for the path versus box hit test, bound to the top level
// depends on pbit_pkg and path_box_intersect_test
module pbit_checker (
    input logic aclk,
    input logic aresetn,
    input logic cfg_valid,
    input logic cfg_ready,
    input logic s_valid,
    input logic s_ready,
    input logic s_path_end,
    input logic m_valid,
    input logic m_ready,
    input logic m_intersects
);
    import pbit_pkg::*;

    // paths closed at the input whose answer has not been taken
    logic [PEND_WIDTH-1:0] pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + PEND_WIDTH'(s_valid && s_ready && s_path_end)
                                 - PEND_WIDTH'(m_valid && m_ready);
        end
    end

    a_cfg_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before taken");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_intersects))
        else $error("result changed while stalled");

    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != '0)
        else $error("result without a closed path");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= PEND_WIDTH'(PIPE_CAPACITY))
        else $error("more open answers than storage");

endmodule

bind path_box_intersect_test pbit_checker u_checker (.*);
